// ===== rtl/core/ard_pkg.sv =====
// Package for the radial dead zone block: sizes, kind codes and the
// pipeline item record. No dependencies.
`default_nettype none
package ard_pkg;

    // Sample and fraction sizes (fraction bits must stay below sample bits)
    localparam int SB  = 16;
    localparam int FB  = 14;
    localparam int TW  = FB;
    localparam int AW  = SB;
    localparam int SSW = 2 * SB;
    localparam int MW  = SSW / 2;
    localparam int NW  = AW + MW;
    localparam int DW  = FB + 1 + MW;
    localparam int QW  = SB;
    localparam int QS  = SB - FB;
    localparam logic [TW-1:0] THRESH_RESET = TW'(3277);

    // Sample kinds
    localparam logic [1:0] CMD_PASS  = 2'd0;
    localparam logic [1:0] CMD_ONE   = 2'd1;
    localparam logic [1:0] CMD_TWO   = 2'd2;
    localparam logic [1:0] CMD_THREE = 2'd3;

    // Record that travels down the pipeline with each request
    typedef struct packed {
        logic [1:0]             cmd;
        logic signed [SB-1:0]   x;
        logic signed [SB-1:0]   y;
        logic signed [SB-1:0]   z;
        logic [2:0][AW-1:0]     a;
        logic [2:0]             neg;
        logic [TW-1:0]          t;
        logic                   dz;
        logic [MW-1:0]          m;
        logic [MW-1:0]          mt;
        logic [DW-1:0]          d;
    } t_item;

endpackage
`default_nettype wire

// ===== rtl/core/ard_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
// Depends on ard_pkg.
`default_nettype none
module ard_sqrt (
    input  wire                     i_clk,
    input  wire                     i_en,
    input  wire [ard_pkg::SSW-1:0]  i_ss,
    output logic [ard_pkg::MW-1:0]  o_root
);
    import ard_pkg::*;

    localparam int RW = MW + 2;

    logic [RW-1:0]  w_rem  [0:MW];
    logic [MW-1:0]  w_root [0:MW];
    logic [SSW-1:0] w_rest [0:MW];

    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_rest[0] = i_ss;

    genvar g;
    generate
        for (g = 0; g < MW; g++) begin : g_stage
            logic [RW+1:0] sh;
            logic [RW+1:0] trial;
            logic          ge;
            logic [RW-1:0] r_rem;
            logic [MW-1:0] r_root;
            logic [SSW-1:0] r_rest;

            // Bring in the next two radicand bits and try a one
            always_comb begin
                sh    = {w_rem[g], w_rest[g][SSW-1 -: 2]};
                trial = (RW+2)'({w_root[g], 2'b01});
                ge    = (sh >= trial);
            end

            // Advance one stage
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem  <= ge ? RW'(sh - trial) : RW'(sh);
                    r_root <= {w_root[g][MW-2:0], ge};
                    r_rest <= {w_rest[g][SSW-3:0], 2'b00};
                end
            end

            assign w_rem[g+1]  = r_rem;
            assign w_root[g+1] = r_root;
            assign w_rest[g+1] = r_rest;
        end
    endgenerate

    assign o_root = w_root[MW];

endmodule
`default_nettype wire

// ===== rtl/core/ard_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on ard_pkg.
`default_nettype none
module ard_div (
    input  wire                     i_clk,
    input  wire                     i_en,
    input  wire [ard_pkg::DW-1:0]   i_rem,
    input  wire [ard_pkg::QW-1:0]   i_lo,
    input  wire [ard_pkg::DW-1:0]   i_div,
    output logic [ard_pkg::QW-1:0]  o_quo,
    output logic [ard_pkg::DW-1:0]  o_rem
);
    import ard_pkg::*;

    logic [DW-1:0] w_rem [0:QW];
    logic [QW-1:0] w_lo  [0:QW];
    logic [QW-1:0] w_quo [0:QW];
    logic [DW-1:0] w_div [0:QW];

    assign w_rem[0] = i_rem;
    assign w_lo[0]  = i_lo;
    assign w_quo[0] = '0;
    assign w_div[0] = i_div;

    genvar g;
    generate
        for (g = 0; g < QW; g++) begin : g_stage
            logic [DW:0]   sh;
            logic          ge;
            logic [DW-1:0] r_rem;
            logic [QW-1:0] r_lo;
            logic [QW-1:0] r_quo;
            logic [DW-1:0] r_div;

            // Shift in one dividend bit and compare with the divisor
            always_comb begin
                sh = {w_rem[g], w_lo[g][QW-1]};
                ge = (sh >= {1'b0, w_div[g]});
            end

            // Advance one stage
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem <= ge ? DW'(sh - {1'b0, w_div[g]}) : DW'(sh);
                    r_lo  <= {w_lo[g][QW-2:0], 1'b0};
                    r_quo <= {w_quo[g][QW-2:0], ge};
                    r_div <= w_div[g];
                end
            end

            assign w_rem[g+1] = r_rem;
            assign w_lo[g+1]  = r_lo;
            assign w_quo[g+1] = r_quo;
            assign w_div[g+1] = r_div;
        end
    endgenerate

    assign o_quo = w_quo[QW];
    assign o_rem = w_rem[QW];

endmodule
`default_nettype wire

// ===== rtl/core/axis_radial_dead_zone.sv =====
// Radial dead zone with rescaling for one to three axis components.
// Pipeline stages: front 3, square root 16, scale 3, divide 16, output 1;
// one request per cycle; the whole pipeline holds while a result is stalled.
// Synchronous active-low reset clears the valid bits and sets the threshold
// to 3277. Depends on ard_pkg, ard_sqrt, ard_div.
`default_nettype none
module axis_radial_dead_zone (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire [1:0]                   i_cmd,
    input  wire signed [ard_pkg::SB-1:0] i_x_in,
    input  wire signed [ard_pkg::SB-1:0] i_y_in,
    input  wire signed [ard_pkg::SB-1:0] i_z_in,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic signed [ard_pkg::SB-1:0] o_x_out,
    output logic signed [ard_pkg::SB-1:0] o_y_out,
    output logic signed [ard_pkg::SB-1:0] o_z_out,
    output logic                        o_in_dead_zone,
    output logic                        o_clipped,
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire [ard_pkg::TW-1:0]       i_cfg_data
);
    import ard_pkg::*;

    logic en;
    logic [TW-1:0] r_thresh;

    assign en          = !(o_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_valid) begin
            r_thresh <= i_cfg_data;
        end
    end

    // Stage A: capture sample, magnitudes and signs
    t_item r_a_item, n_a_item;
    logic  r_a_vld;
    always_comb begin
        n_a_item     = '0;
        n_a_item.cmd = i_cmd;
        n_a_item.x   = i_x_in;
        n_a_item.y   = i_y_in;
        n_a_item.z   = i_z_in;
        n_a_item.neg = {i_z_in[SB-1], i_y_in[SB-1], i_x_in[SB-1]};
        n_a_item.a[0] = i_x_in[SB-1] ? AW'(~i_x_in + 1'b1) : AW'(i_x_in);
        n_a_item.a[1] = i_y_in[SB-1] ? AW'(~i_y_in + 1'b1) : AW'(i_y_in);
        n_a_item.a[2] = i_z_in[SB-1] ? AW'(~i_z_in + 1'b1) : AW'(i_z_in);
        n_a_item.t   = r_thresh;
    end

    // Stage B: squares
    t_item r_b_item;
    logic  r_b_vld;
    logic [2:0][SSW-1:0] r_b_sq;
    logic [2*TW-1:0]     r_b_tt;

    // Stage C: sum of squares and dead zone test
    t_item r_c_item, n_c_item;
    logic  r_c_vld;
    logic [SSW-1:0] r_c_ss, n_c_ss;
    always_comb begin
        n_c_item = r_b_item;
        n_c_ss   = r_b_sq[0] + r_b_sq[1];
        if (r_b_item.cmd == CMD_THREE) begin
            n_c_ss = n_c_ss + r_b_sq[2];
        end
        case (r_b_item.cmd)
            CMD_ONE:   n_c_item.dz = (r_b_item.a[0] < AW'(r_b_item.t));
            CMD_TWO,
            CMD_THREE: n_c_item.dz = (n_c_ss < SSW'(r_b_tt));
            default:   n_c_item.dz = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_in_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_item  <= n_a_item;
            r_b_item  <= r_a_item;
            r_b_sq[0] <= SSW'(r_a_item.a[0] * r_a_item.a[0]);
            r_b_sq[1] <= SSW'(r_a_item.a[1] * r_a_item.a[1]);
            r_b_sq[2] <= SSW'(r_a_item.a[2] * r_a_item.a[2]);
            r_b_tt    <= (2*TW)'(r_a_item.t * r_a_item.t);
            r_c_item  <= n_c_item;
            r_c_ss    <= n_c_ss;
        end
    end

    // Square root with the record delayed alongside
    logic [MW-1:0] root;
    ard_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_ss   (r_c_ss),
        .o_root (root)
    );

    t_item r_sq_item [0:MW-1];
    logic  r_sq_vld  [0:MW-1];

    genvar g;
    generate
        for (g = 0; g < MW; g++) begin : g_sqd
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sq_vld[g] <= 1'b0;
                end else if (en) begin
                    r_sq_vld[g] <= (g == 0) ? r_c_vld : r_sq_vld[(g == 0) ? 0 : g-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_sq_item[g] <= (g == 0) ? r_c_item : r_sq_item[(g == 0) ? 0 : g-1];
                end
            end
        end
    endgenerate

    // Stage D: divisor and magnitude excess
    t_item r_d_item, n_d_item;
    logic  r_d_vld;
    logic [FB:0] omt;
    always_comb begin
        omt       = (FB+1)'(1 << FB) - {1'b0, r_sq_item[MW-1].t};
        n_d_item  = r_sq_item[MW-1];
        n_d_item.m  = root;
        n_d_item.mt = root - MW'(r_sq_item[MW-1].t);
        n_d_item.d  = DW'(DW'(omt) * DW'(root));
    end

    // Stage E: numerators
    t_item r_e_item;
    logic  r_e_vld;
    logic [2:0][NW-1:0] r_e_n;

    // Stage F: overflow precheck and divider start values
    t_item r_f_item;
    logic  r_f_vld;
    logic [2:0]         r_f_big;
    logic [2:0][DW-1:0] r_f_rem;
    logic [2:0][QW-1:0] r_f_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else if (en) begin
            r_d_vld <= r_sq_vld[MW-1];
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_item <= n_d_item;
            r_e_item <= r_d_item;
            for (int i = 0; i < 3; i++) begin
                r_e_n[i]   <= NW'(r_d_item.a[i] * r_d_item.mt);
                r_f_big[i] <= ((DW+QS)'(r_e_n[i]) >= {r_e_item.d, QS'(0)});
                r_f_rem[i] <= DW'(r_e_n[i] >> QS);
                r_f_lo[i]  <= {r_e_n[i][QS-1:0], FB'(0)};
            end
            r_f_item <= r_e_item;
        end
    end

    // Three divider lanes
    logic [2:0][QW-1:0] quo;
    logic [2:0][DW-1:0] rem;
    generate
        for (g = 0; g < 3; g++) begin : g_lane
            ard_div u_div (
                .i_clk (i_clk),
                .i_en  (en),
                .i_rem (r_f_rem[g]),
                .i_lo  (r_f_lo[g]),
                .i_div (r_f_item.d),
                .o_quo (quo[g]),
                .o_rem (rem[g])
            );
        end
    endgenerate

    t_item      r_dv_item [0:QW-1];
    logic       r_dv_vld  [0:QW-1];
    logic [2:0] r_dv_big  [0:QW-1];
    generate
        for (g = 0; g < QW; g++) begin : g_dvd
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv_vld[g] <= 1'b0;
                end else if (en) begin
                    r_dv_vld[g] <= (g == 0) ? r_f_vld : r_dv_vld[(g == 0) ? 0 : g-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dv_item[g] <= (g == 0) ? r_f_item : r_dv_item[(g == 0) ? 0 : g-1];
                    r_dv_big[g]  <= (g == 0) ? r_f_big  : r_dv_big[(g == 0) ? 0 : g-1];
                end
            end
        end
    endgenerate

    // Stage G: round, sign, saturate and select by kind
    t_item                     it;
    logic [2:0][SB-1:0]        lane_val;
    logic [2:0]                lane_clip;
    logic [QW:0]               qf;
    logic                      rnd;
    logic signed [SB-1:0]      n_x, n_y, n_z;
    logic                      n_dz, n_clip;
    logic                      r_out_vld;

    always_comb begin
        it = r_dv_item[QW-1];
        for (int i = 0; i < 3; i++) begin
            rnd = ({rem[i], 1'b0} >= {1'b0, it.d});
            qf  = (QW+1)'(quo[i]) + (QW+1)'(rnd);
            if (r_dv_big[QW-1][i]) begin
                lane_clip[i] = 1'b1;
            end else if (it.neg[i]) begin
                lane_clip[i] = (qf > (QW+1)'(1 << (SB-1)));
            end else begin
                lane_clip[i] = (qf >= (QW+1)'(1 << (SB-1)));
            end
            if (lane_clip[i]) begin
                lane_val[i] = it.neg[i] ? {1'b1, (SB-1)'(0)} : {1'b0, {(SB-1){1'b1}}};
            end else if (it.neg[i]) begin
                lane_val[i] = SB'((QW+1)'(0) - qf);
            end else begin
                lane_val[i] = SB'(qf);
            end
        end

        n_x = '0;
        n_y = '0;
        n_z = '0;
        n_dz = it.dz;
        n_clip = 1'b0;
        case (it.cmd)
            CMD_PASS: begin
                n_x  = it.x;
                n_y  = it.y;
                n_z  = it.z;
                n_dz = 1'b0;
            end
            CMD_ONE: begin
                if (!it.dz) begin
                    n_x = it.x;
                end
            end
            CMD_TWO: begin
                if (!it.dz && it.m != '0) begin
                    n_x    = lane_val[0];
                    n_y    = lane_val[1];
                    n_clip = lane_clip[0] | lane_clip[1];
                end
            end
            CMD_THREE: begin
                if (!it.dz && it.m != '0) begin
                    n_x    = lane_val[0];
                    n_y    = lane_val[1];
                    n_z    = lane_val[2];
                    n_clip = |lane_clip;
                end
            end
            default: begin
                n_dz = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_dv_vld[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_x_out        <= n_x;
            o_y_out        <= n_y;
            o_z_out        <= n_z;
            o_in_dead_zone <= n_dz;
            o_clipped      <= n_clip;
        end
    end

    assign o_out_valid = r_out_vld;

endmodule
`default_nettype wire
